// ===== rtl/segment_tree_range_query_defines.svh =====
// Assertion macros for the segment tree range query block.
// Included by the top level; no other dependencies.
`ifndef SEGMENT_TREE_RANGE_QUERY_DEFINES_SVH
`define SEGMENT_TREE_RANGE_QUERY_DEFINES_SVH

`ifndef SYNTH
`define STQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stq assertion failed");
`define STQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stq assertion failed");
`else
`define STQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define STQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/stq_pkg.sv =====
// Shared constants, mode codes and identity lookup for the segment tree block.
// No dependencies.
package stq_pkg;

  localparam int STQ_LEAVES = 1024;
  localparam int DATA_W     = 64;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int REG_W      = 1;

  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

  localparam logic [REG_W-1:0] REG_COMBINE_MODE = 1'b0;

  localparam logic              OP_UPDATE = 1'b0;
  localparam logic              OP_QUERY  = 1'b1;

  localparam logic signed [DATA_W-1:0] MIN_IDENTITY = 64'sd10000000000000000;
  localparam logic signed [DATA_W-1:0] MAX_IDENTITY = -64'sd10000000000000000;

  function automatic logic signed [DATA_W-1:0] identity_of(input logic [MODE_W-1:0] mode);
    logic signed [DATA_W-1:0] id;
    case (mode)
      MODE_MIN: id = MIN_IDENTITY;
      MODE_MAX: id = MAX_IDENTITY;
      default:  id = '0;
    endcase
    return id;
  endfunction

endpackage

// ===== rtl/stq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/stq_combine.sv =====
// Combine unit: signed minimum, signed maximum or wrapping sum of two words.
// Depends on stq_pkg.
module stq_combine import stq_pkg::*; (
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] y
);

  always_comb begin
    case (mode)
      MODE_MIN: y = (b < a) ? b : a;
      MODE_MAX: y = (a < b) ? b : a;
      default:  y = a + b;
    endcase
  end

endmodule

// ===== rtl/segment_tree_range_query.sv =====
// Segment tree, point update and half-open range query, nodes in one RAM.
// Depends on stq_pkg, stq_ram, stq_combine and the assertion macro header.
//
// Leaves are rounded up to a power of two, SPAN (1024 at the default), and the
// nodes sit in one RAM of 2*SPAN words with one write and one registered read
// port. On an update the leaf is written while its sibling is read, then each
// step writes one ancestor and reads the next sibling. A query walks the tree
// bottom up; at a level where the left border needs a node read, that read has
// a step of its own, and the right border read shares the step that moves both
// borders up. A finishing step, which the last left read may share, ends the
// query; the single read port is why the two border reads take separate steps.
// A result still waiting in the output register stalls the finishing step. An
// update beyond the leaves is accepted and dropped. After reset and after every
// write of combine_mode a clearing pass writes the identity into all 2*SPAN
// words, during which no word is accepted. A finished result waits in an
// output register while the next word is taken.
`include "segment_tree_range_query_defines.svh"

module segment_tree_range_query import stq_pkg::*; #(
  parameter int LEAVES = STQ_LEAVES,
  localparam int SPAN   = 1 << $clog2(LEAVES),
  localparam int DEPTH  = 2 * SPAN,
  localparam int IDX_W  = $clog2(DEPTH),
  localparam int NODE_W = IDX_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [9:0]               position,
  input  logic signed [DATA_W-1:0] value,
  input  logic [10:0]              range_start,
  input  logic [10:0]              range_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_QRY   = 2'd3;

  logic [1:0]               state, state_next;
  logic [MODE_W-1:0]        combine_mode, combine_mode_next;
  logic [IDX_W-1:0]         clr_addr, clr_addr_next;
  logic [IDX_W-1:0]         cur, cur_next;
  logic [NODE_W-1:0]        lo, lo_next, hi, hi_next;
  logic                     phase, phase_next;
  logic                     rd_pend, rd_pend_next;
  logic signed [DATA_W-1:0] acc, acc_next;
  logic signed [DATA_W-1:0] result_next;
  logic                     out_valid_next;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata, comb, acc_eff;

  logic                     cfg_wr, in_accept;
  logic [31:0]              a32, b32, b_cl;
  logic [IDX_W-1:0]         leaf, parent;
  logic [NODE_W-1:0]        hi_dec;

  stq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stq_combine u_combine (
    .mode (combine_mode),
    .a    (acc),
    .b    (mem_rdata),
    .y    (comb)
  );

  assign pready    = 1'b1;
  assign prdata    = (paddr[ADDR_W-1:2] == REG_COMBINE_MODE) ?
                     {{(32-MODE_W){1'b0}}, combine_mode} : '0;
  assign cfg_wr    = psel && penable && pwrite &&
                     (paddr[ADDR_W-1:2] == REG_COMBINE_MODE);
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  assign a32    = 32'(range_start);
  assign b32    = 32'(range_end);
  assign b_cl   = (b32 > 32'(LEAVES)) ? 32'(LEAVES) : b32;
  assign leaf   = IDX_W'(32'(position) + 32'(SPAN));
  assign parent = {1'b0, cur[IDX_W-1:1]};
  assign hi_dec = hi - NODE_W'(1);
  assign acc_eff = rd_pend ? comb : acc;

  always_comb begin
    state_next        = state;
    combine_mode_next = combine_mode;
    clr_addr_next     = clr_addr;
    cur_next          = cur;
    lo_next           = lo;
    hi_next           = hi;
    phase_next        = phase;
    rd_pend_next      = 1'b0;
    acc_next          = acc;
    result_next       = result;
    out_valid_next    = out_valid && !out_ready;
    mem_we            = 1'b0;
    mem_waddr         = clr_addr;
    mem_wdata         = identity_of(combine_mode);
    mem_raddr         = '0;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (op == OP_QUERY) begin
            if (a32 < b_cl) begin
              lo_next = NODE_W'(a32 + 32'(SPAN));
              hi_next = NODE_W'(b_cl + 32'(SPAN));
            end else begin
              lo_next = '0;
              hi_next = '0;
            end
            phase_next = 1'b0;
            acc_next   = identity_of(combine_mode);
            state_next = S_QRY;
          end else if (32'(position) < 32'(LEAVES)) begin
            mem_we     = 1'b1;
            mem_waddr  = leaf;
            mem_wdata  = value;
            mem_raddr  = leaf ^ IDX_W'(1);
            acc_next   = value;
            cur_next   = leaf;
            state_next = S_UPD;
          end
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + IDX_W'(1);
        end
      end
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = comb;
        mem_raddr = parent ^ IDX_W'(1);
        acc_next  = comb;
        cur_next  = parent;
        if (parent == IDX_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_QRY: begin
        acc_next = acc_eff;
        if (lo >= hi) begin
          if (!out_valid || out_ready) begin
            result_next    = acc_eff;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else if (!phase && lo[0]) begin
          mem_raddr    = lo[IDX_W-1:0];
          rd_pend_next = 1'b1;
          lo_next      = lo + NODE_W'(1);
          phase_next   = 1'b1;
        end else begin
          if (hi[0]) begin
            mem_raddr    = hi_dec[IDX_W-1:0];
            rd_pend_next = 1'b1;
            hi_next      = hi_dec >> 1;
          end else begin
            hi_next = hi >> 1;
          end
          lo_next    = lo >> 1;
          phase_next = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cfg_wr) begin
      combine_mode_next = pwdata[MODE_W-1:0];
      clr_addr_next     = '0;
      state_next        = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      combine_mode <= MODE_MAX;
      clr_addr     <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      combine_mode <= combine_mode_next;
      clr_addr     <= clr_addr_next;
      rd_pend      <= rd_pend_next;
      out_valid    <= out_valid_next;
    end
    cur    <= cur_next;
    lo     <= lo_next;
    hi     <= hi_next;
    phase  <= phase_next;
    acc    <= acc_next;
    result <= result_next;
  end

  `STQ_ASSERT_SAME(a_pend_in_query, clk, rst, rd_pend, state == S_QRY)
  `STQ_ASSERT_NEXT(a_cfg_clears, clk, rst, cfg_wr, (state == S_CLEAR) && (clr_addr == '0))
  `STQ_ASSERT_SAME(a_upd_above_root, clk, rst, state == S_UPD, cur > IDX_W'(1))
  `STQ_ASSERT_NEXT(a_query_no_early, clk, rst, in_accept && (op == OP_QUERY) && !cfg_wr,
                   state == S_QRY)

endmodule
